### rtl/bwes_pkg.sv
package bwes_pkg;

    localparam int BWES_NUM_WALKERS = 1024;
    localparam int BWES_NUM_FORCES  = 256;
    localparam int BWES_GRID_POINTS = 32;

    localparam int OP_W     = 2;
    localparam int WIDX_W   = 10;
    localparam int ROW_W    = 8;
    localparam int SMP_W    = 5;
    localparam int POT_W    = 16;
    localparam int RAND_W   = 16;
    localparam int STEP_W   = 20;
    localparam int POS_W    = 21;
    localparam int CNT_W    = 20;
    localparam int FORCE_W  = 24;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 1;

    localparam int WALKER_W = POS_W + CNT_W + STEP_W;

    localparam logic [CFG_W-1:0] DRIFT_GAIN_RST      = 32'd214748;
    localparam logic [CFG_W-1:0] NOISE_AMPLITUDE_RST = 32'd94098009;

    localparam logic [CFG_IDX_W-1:0] CFG_DRIFT_GAIN      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_AMPLITUDE = 1'd1;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_CLEAR = 2'd1,
        OP_STEP  = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

endpackage

### rtl/bwes_ram.sv
module bwes_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/brownian_walker_exit_step_unit.sv
// channel   direction  handshake                    payload
// input     in         i_in_valid / o_in_ready      i_operation .. i_step_number
// result    out        o_out_valid / i_out_ready    o_operation_done .. o_last_exit_step
// config    in         i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// one item at a time: a load passes LOAD and FIN, a clear or no-op FIN alone; a step runs
// through the walker read-modify-write sequence and the two force reads through one read port
// after reset a pass zeroes the walker memory, with the input held off
// a finished result waits in the output register; the next item is taken meanwhile and
// its final cycle stalls until that result has been transferred
// config writes are taken in every cycle
module brownian_walker_exit_step_unit
    import bwes_pkg::*;
#(
    parameter int NUM_WALKERS = BWES_NUM_WALKERS,
    parameter int NUM_FORCES  = BWES_NUM_FORCES,
    parameter int GRID_POINTS = BWES_GRID_POINTS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [OP_W-1:0]      i_operation,
    input  logic [WIDX_W-1:0]    i_walker_index,
    input  logic [ROW_W-1:0]     i_force_row,
    input  logic [SMP_W-1:0]     i_sample_index,
    input  logic signed [POT_W-1:0] i_potential_value,
    input  logic [RAND_W-1:0]    i_random_uniform,
    input  logic [STEP_W-1:0]    i_step_number,

    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [OP_W-1:0]      o_operation_done,
    output logic [POS_W-1:0]     o_position,
    output logic                 o_exited,
    output logic [CNT_W-1:0]     o_exit_total,
    output logic [STEP_W-1:0]    o_last_exit_step,

    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int WAW  = $clog2(NUM_WALKERS);
    localparam int FTD  = NUM_FORCES * GRID_POINTS;
    localparam int FTAW = $clog2(FTD);
    localparam int LW   = $clog2(GRID_POINTS);
    localparam int SW   = POS_W + $clog2(GRID_POINTS) + 1;
    localparam int IW   = SW - 20;
    localparam int WIDX_MAX = (1 << WIDX_W) - 1;

    localparam logic signed [26:0] LD_MAX = 27'sd8388607;
    localparam logic signed [26:0] LD_MIN = -27'sd8388608;
    localparam logic [34:0] ONE_Q20 = 35'd1048576;

    typedef enum logic [11:0] {
        S_INIT = 12'b0000_0000_0001,
        S_IDLE = 12'b0000_0000_0010,
        S_LOAD = 12'b0000_0000_0100,
        S_RDW  = 12'b0000_0000_1000,
        S_POS  = 12'b0000_0001_0000,
        S_RDLO = 12'b0000_0010_0000,
        S_RDHI = 12'b0000_0100_0000,
        S_INTP = 12'b0000_1000_0000,
        S_FRC  = 12'b0001_0000_0000,
        S_DRF  = 12'b0010_0000_0000,
        S_NEW  = 12'b0100_0000_0000,
        S_FIN  = 12'b1000_0000_0000
    } t_state;

    // remainder by a constant through conditional subtraction
    function automatic logic [WIDX_W-1:0] mod_const(input logic [WIDX_W-1:0] x,
                                                    input int unsigned d);
        logic [WIDX_W-1:0] r;
        r = x;
        for (int k = WIDX_W - 1; k >= 0; k--) begin
            if ((d << k) <= WIDX_MAX && r >= WIDX_W'(d << k)) begin
                r = r - WIDX_W'(d << k);
            end
        end
        return r;
    endfunction

    t_state r_state, n_state;
    logic [WAW-1:0] r_clr;

    logic [CFG_W-1:0] r_drift_gain;
    logic [CFG_W-1:0] r_noise_amp;
    logic signed [POT_W-1:0] r_prev_pot;

    t_op                r_op;
    logic [WIDX_W-1:0]  r_wmod;
    logic [ROW_W-1:0]   r_row;
    logic [SMP_W-1:0]   r_smp;
    logic signed [POT_W-1:0] r_pot;
    logic [RAND_W-1:0]  r_rand;
    logic [STEP_W-1:0]  r_stepno;

    logic               r_lwe;
    logic [FTAW-1:0]    r_laddr;
    logic [FORCE_W-1:0] r_fval;

    logic [FTAW-1:0]    r_fbase;
    logic [POS_W-1:0]   r_pos;
    logic [CNT_W-1:0]   r_cnt;
    logic [STEP_W-1:0]  r_xstep;
    logic [LW-1:0]      r_lo;
    logic [LW-1:0]      r_hi;
    logic [19:0]        r_frac;
    logic signed [FORCE_W-1:0] r_flo;
    logic signed [45:0] r_iprod;
    logic signed [50:0] r_nprod;
    logic signed [FORCE_W-1:0] r_force;
    logic signed [21:0] r_noise;
    logic signed [56:0] r_dprod;
    logic signed [34:0] r_np;

    logic               r_out_valid;
    t_op                r_out_op;
    logic [POS_W-1:0]   r_out_pos;
    logic               r_out_exited;
    logic [CNT_W-1:0]   r_out_cnt;
    logic [STEP_W-1:0]  r_out_last;

    logic                w_accept;
    logic                w_out_free;
    logic                w_fin;

    logic                w_wwe;
    logic [WAW-1:0]      w_waddr;
    logic [WALKER_W-1:0] w_wdata;
    logic [WALKER_W-1:0] w_wrdata;
    logic                w_fwe;
    logic [FTAW-1:0]     w_fraddr;
    logic [FORCE_W-1:0]  w_frdata;

    logic [SW-1:0]       w_s;
    logic [IW-1:0]       w_idx;
    logic [LW-1:0]       w_lo;

    logic signed [POT_W-1:0] w_prev;
    logic signed [16:0]  w_dp;
    logic signed [26:0]  w_fprod;
    logic signed [26:0]  w_fneg;

    logic signed [24:0]  w_diff;
    logic signed [20:0]  w_frac_s;
    logic signed [17:0]  w_nd;
    logic signed [32:0]  w_namp_s;
    logic signed [32:0]  w_dg_s;
    logic signed [25:0]  w_force;

    logic [38:0]         w_t;
    logic                w_nneg;
    logic [38:0]         w_m;
    logic [19:0]         w_a;
    logic [20:0]         w_sab;
    logic [16:0]         w_s2;
    logic [20:0]         w_q;
    logic signed [32:0]  w_drift;

    logic [34:0]         w_mag;
    logic                w_exit;
    logic [POS_W-1:0]    w_newpos;
    logic [CNT_W-1:0]    w_ncnt;
    logic [STEP_W-1:0]   w_nxs;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_fin       = (r_state == S_FIN) && w_out_free;

    // memories
    assign w_wwe   = (r_state == S_INIT) ||
                     (w_fin && (r_op == OP_CLEAR || r_op == OP_STEP));
    assign w_waddr = (r_state == S_INIT) ? r_clr : WAW'(r_wmod);
    assign w_wdata = (w_fin && r_op == OP_STEP) ? {w_newpos, w_ncnt, w_nxs} : '0;
    assign w_fwe   = w_fin && r_op == OP_LOAD && r_lwe;
    assign w_fraddr = (r_state == S_RDLO) ? r_fbase + FTAW'(r_lo) : r_fbase + FTAW'(r_hi);

    bwes_ram #(
        .WIDTH (WALKER_W),
        .DEPTH (NUM_WALKERS)
    ) u_walker_ram (
        .i_clk   (i_clk),
        .i_we    (w_wwe),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (WAW'(r_wmod)),
        .o_rdata (w_wrdata)
    );

    bwes_ram #(
        .WIDTH (FORCE_W),
        .DEPTH (FTD)
    ) u_force_ram (
        .i_clk   (i_clk),
        .i_we    (w_fwe),
        .i_waddr (r_laddr),
        .i_wdata (r_fval),
        .i_raddr (w_fraddr),
        .o_rdata (w_frdata)
    );

    // grid cell of the stored position
    assign w_s   = SW'(w_wrdata[WALKER_W-1 -: POS_W]) * SW'(GRID_POINTS);
    assign w_idx = w_s[SW-1:20];
    assign w_lo  = (w_idx >= IW'(GRID_POINTS)) ? LW'(w_idx - IW'(GRID_POINTS)) : LW'(w_idx);

    // force table entry from the potential samples
    assign w_prev  = (r_smp == '0) ? '0 : r_prev_pot;
    assign w_dp    = {r_pot[POT_W-1], r_pot} - {w_prev[POT_W-1], w_prev};
    assign w_fprod = {{10{w_dp[16]}}, w_dp} * $signed(27'(GRID_POINTS));
    assign w_fneg  = -w_fprod;

    // interpolation and noise products
    assign w_diff   = {w_frdata[FORCE_W-1], w_frdata} - {r_flo[FORCE_W-1], r_flo};
    assign w_frac_s = {1'b0, r_frac};
    assign w_nd     = $signed({1'b0, r_rand, 1'b0}) - 18'sd65535;
    assign w_namp_s = {1'b0, r_noise_amp};
    assign w_dg_s   = {1'b0, r_drift_gain};
    assign w_force  = r_iprod[45:20] + {{2{r_flo[FORCE_W-1]}}, r_flo};

    // floor division by 65535 * 4096, negative values through the complement
    assign w_t     = r_nprod[50:12];
    assign w_nneg  = r_nprod[50];
    assign w_m     = w_nneg ? ~w_t : w_t;
    assign w_a     = w_m[35:16];
    assign w_sab   = {1'b0, w_a} + {5'b0, w_m[15:0]};
    assign w_s2    = {12'b0, w_sab[20:16]} + {1'b0, w_sab[15:0]};
    assign w_q     = {1'b0, w_a} + {16'b0, w_sab[20:16]} + {20'b0, (w_s2 >= 17'd65535)};

    assign w_drift = r_dprod[56:24];

    // reflect, exit and restart
    assign w_mag    = r_np[34] ? 35'(-r_np) : 35'(r_np);
    assign w_exit   = w_mag > ONE_Q20;
    assign w_newpos = w_exit ? '0 : w_mag[POS_W-1:0];
    assign w_ncnt   = (w_exit && r_cnt != '1) ? r_cnt + 1'b1 : r_cnt;
    assign w_nxs    = w_exit ? r_stepno : r_xstep;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT: begin
                if (r_clr == WAW'(NUM_WALKERS - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (t_op'(i_operation))
                        OP_LOAD:  n_state = S_LOAD;
                        OP_CLEAR: n_state = S_FIN;
                        OP_STEP:  n_state = S_RDW;
                        OP_NOP:   n_state = S_FIN;
                    endcase
                end
            end
            S_LOAD: n_state = S_FIN;
            S_RDW:  n_state = S_POS;
            S_POS:  n_state = S_RDLO;
            S_RDLO: n_state = S_RDHI;
            S_RDHI: n_state = S_INTP;
            S_INTP: n_state = S_FRC;
            S_FRC:  n_state = S_DRF;
            S_DRF:  n_state = S_NEW;
            S_NEW:  n_state = S_FIN;
            S_FIN: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_INIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_INIT;
            r_clr        <= '0;
            r_out_valid  <= 1'b0;
            r_prev_pot   <= '0;
            r_drift_gain <= DRIFT_GAIN_RST;
            r_noise_amp  <= NOISE_AMPLITUDE_RST;
        end else begin
            r_state <= n_state;
            if (r_state == S_INIT) begin
                r_clr <= r_clr + 1'b1;
            end
            if (w_fin) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_fwe) begin
                r_prev_pot <= r_pot;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_DRIFT_GAIN:      r_drift_gain <= i_cfg_data;
                    CFG_NOISE_AMPLITUDE: r_noise_amp  <= i_cfg_data;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op     <= t_op'(i_operation);
            r_wmod   <= mod_const(i_walker_index, NUM_WALKERS);
            r_row    <= i_force_row;
            r_smp    <= i_sample_index;
            r_pot    <= i_potential_value;
            r_rand   <= i_random_uniform;
            r_stepno <= i_step_number;
        end
        if (r_state == S_LOAD) begin
            r_lwe   <= (int'(r_row) < NUM_FORCES) && (int'(r_smp) < GRID_POINTS);
            r_laddr <= FTAW'(int'(r_row) * GRID_POINTS + int'(r_smp));
            if (w_fneg > LD_MAX) begin
                r_fval <= LD_MAX[FORCE_W-1:0];
            end else if (w_fneg < LD_MIN) begin
                r_fval <= LD_MIN[FORCE_W-1:0];
            end else begin
                r_fval <= w_fneg[FORCE_W-1:0];
            end
        end
        if (r_state == S_RDW) begin
            r_fbase <= FTAW'(int'(mod_const(r_wmod, NUM_FORCES)) * GRID_POINTS);
        end
        if (r_state == S_POS) begin
            r_pos   <= w_wrdata[WALKER_W-1 -: POS_W];
            r_cnt   <= w_wrdata[STEP_W +: CNT_W];
            r_xstep <= w_wrdata[STEP_W-1:0];
            r_lo    <= w_lo;
            r_hi    <= (w_lo == LW'(GRID_POINTS - 1)) ? '0 : w_lo + 1'b1;
            r_frac  <= w_s[19:0];
        end
        if (r_state == S_RDHI) begin
            r_flo <= w_frdata;
        end
        if (r_state == S_INTP) begin
            r_iprod <= w_frac_s * w_diff;
            r_nprod <= w_namp_s * w_nd;
        end
        if (r_state == S_FRC) begin
            r_force <= w_force[FORCE_W-1:0];
            r_noise <= w_nneg ? ~$signed({1'b0, w_q}) : $signed({1'b0, w_q});
        end
        if (r_state == S_DRF) begin
            r_dprod <= w_dg_s * r_force;
        end
        if (r_state == S_NEW) begin
            r_np <= $signed({14'b0, r_pos}) + {{2{w_drift[32]}}, w_drift}
                    + {{13{r_noise[21]}}, r_noise};
        end
        if (w_fin) begin
            r_out_op <= r_op;
            if (r_op == OP_STEP) begin
                r_out_pos    <= w_newpos;
                r_out_exited <= w_exit;
                r_out_cnt    <= w_ncnt;
                r_out_last   <= w_nxs;
            end else begin
                r_out_pos    <= '0;
                r_out_exited <= 1'b0;
                r_out_cnt    <= '0;
                r_out_last   <= '0;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_operation_done = r_out_op;
    assign o_position       = r_out_pos;
    assign o_exited         = r_out_exited;
    assign o_exit_total     = r_out_cnt;
    assign o_last_exit_step = r_out_last;

`ifndef SYNTHESIS
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_position <= 21'd1048576)
        else $error("result position above one");

    a_exit_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_exited) |->
            (o_position == '0 && o_operation_done == OP_STEP && o_exit_total != '0))
        else $error("exit without restart or count");

    a_non_step_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_operation_done != OP_STEP) |->
            (o_position == '0 && !o_exited && o_exit_total == '0 && o_last_exit_step == '0))
        else $error("non-step result carries walker data");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second item taken while one is at work");
`endif

endmodule
